FILE: hw/rtl/hcg_pkg.sv
// hcg_pkg: shared types, constants and SHA-1 helper functions
// for the HOTP code generator; used by every module under hw/rtl
package hcg_pkg;

   // widths
   localparam int HASH_W      = 160;
   localparam int BLOCK_W     = 512;
   localparam int BLOCK_BYTES = 64;
   localparam int KEY_WORDS   = 6;
   localparam int KEY_W       = 64 * KEY_WORDS;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int BCD_W       = 40;
   localparam int DBC_W       = 31;
   localparam int HI_W        = 12;

   // sha-1 schedule and pipeline depth
   localparam int ROUNDS      = 80;
   localparam int BCD_STAGES  = 8;
   localparam int BCD_STEPS   = 4;

   // key handling
   localparam int MAX_KEY_BYTES = 48;
   localparam logic [5:0] KEY_LEN_RESET   = 6'd20;
   localparam logic [3:0] DIGITS_RESET    = 4'd6;
   localparam logic [3:0] MIN_DIGITS      = 4'd6;
   localparam logic [3:0] MAX_DIGITS      = 4'd9;

   // message padding: inner is 64 key bytes plus 8 counter bytes,
   // outer is 64 key bytes plus a 20 byte digest
   localparam logic [31:0] PAD_WORD       = 32'h8000_0000;
   localparam logic [63:0] INNER_LEN_BITS = 64'd576;
   localparam logic [63:0] OUTER_LEN_BITS = 64'd672;

   localparam logic [BLOCK_W-1:0] IPAD_BLOCK = {BLOCK_BYTES{8'h36}};
   localparam logic [BLOCK_W-1:0] OPAD_BLOCK = {BLOCK_BYTES{8'h5C}};

   localparam logic [HASH_W-1:0] SHA1_INIT =
      {32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0};

   localparam logic [31:0] K_0 = 32'h5A82_7999;
   localparam logic [31:0] K_1 = 32'h6ED9_EBA1;
   localparam logic [31:0] K_2 = 32'h8F1B_BCDC;
   localparam logic [31:0] K_3 = 32'hCA62_C1D6;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_WORD_0  = 3'd0,
      CSR_KEY_WORD_1  = 3'd1,
      CSR_KEY_WORD_2  = 3'd2,
      CSR_KEY_WORD_3  = 3'd3,
      CSR_KEY_WORD_4  = 3'd4,
      CSR_KEY_WORD_5  = 3'd5,
      CSR_KEY_LENGTH  = 3'd6,
      CSR_DIGIT_COUNT = 3'd7
   } csr_index_type;

   // key midstate sequencer
   typedef enum logic [2:0] {
      MS_LOAD_IN,
      MS_RUN_IN,
      MS_LOAD_OUT,
      MS_RUN_OUT,
      MS_STORE,
      MS_READY
   } ms_state_type;

   typedef struct packed {
      logic              ready;
      logic [HASH_W-1:0] ihash;
      logic [HASH_W-1:0] ohash;
   } midstate_type;

   // one sha-1 round
   function automatic logic [HASH_W-1:0] sha1_round(input logic [HASH_W-1:0] s,
                                                   input logic [31:0] w,
                                                   input logic [6:0] r);
      logic [31:0] a, b, c, d, e, f, k, t;
      a = s[159:128];
      b = s[127:96];
      c = s[95:64];
      d = s[63:32];
      e = s[31:0];
      if (r < 7'd20) begin
         f = (b & c) | (~b & d);
         k = K_0;
      end else if (r < 7'd40) begin
         f = b ^ c ^ d;
         k = K_1;
      end else if (r < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
         k = K_2;
      end else begin
         f = b ^ c ^ d;
         k = K_3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w;
      return {t, a, {b[1:0], b[31:2]}, c, d};
   endfunction

   // slide the 16 word schedule window by one word
   function automatic logic [BLOCK_W-1:0] sched_next(input logic [BLOCK_W-1:0] win);
      logic [31:0] x;
      x = win[95:64] ^ win[255:224] ^ win[447:416] ^ win[511:480];
      return {win[BLOCK_W-33:0], x[30:0], x[31]};
   endfunction

   // word-wise add of chaining value
   function automatic logic [HASH_W-1:0] hash_add(input logic [HASH_W-1:0] h,
                                                 input logic [HASH_W-1:0] s);
      logic [HASH_W-1:0] res;
      for (int i = 0; i < 5; i++) begin
         res[32*i +: 32] = h[32*i +: 32] + s[32*i +: 32];
      end
      return res;
   endfunction

   // double dabble: one correction and shift
   function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                    input logic bit_in);
      logic [BCD_W-1:0] adj;
      for (int i = 0; i < BCD_W / 4; i++) begin
         adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
      end
      return {adj[BCD_W-2:0], bit_in};
   endfunction

   // modulus for each legal digit count, zero otherwise
   function automatic logic [29:0] ten_pow(input logic [3:0] d);
      logic [29:0] p;
      unique case (d)
         4'd6:    p = 30'd1000000;
         4'd7:    p = 30'd10000000;
         4'd8:    p = 30'd100000000;
         4'd9:    p = 30'd1000000000;
         default: p = '0;
      endcase
      return p;
   endfunction

endpackage

FILE: hw/rtl/hotp_code_generator_top.sv
// hotp_code_generator_top: hmac-sha1 hotp pipeline with dynamic truncation
// and decimal reduction; uses hcg_pkg, hcg_midstate, hcg_compress, hcg_bin2bcd
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_moving_factor
//   rsp     | out       | rsp_valid/rsp_stall | rsp_code_value, rsp_code_bcd, rsp_status
//   csr     | in        | csr_write_en        | csr_index, csr_write_data
//
// one transaction per cycle while req_stall is low; the path runs through two 80 round sha-1
// pipelines plus digest, truncation, 8 stage bcd, reduction and output stages
// after reset and after every register write the key midstates are rehashed
// by one shared round unit, and req_stall stays high until they are ready
// rsp_stall with rsp_valid high freezes every stage at once; nothing is dropped or repeated
// reset is synchronous, active high; resets valid bits and configuration registers
module hotp_code_generator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [63:0]                     req_moving_factor,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [29:0]                     rsp_code_value,
   output logic [35:0]                     rsp_code_bcd,
   output logic                            rsp_status,
   input  logic                            csr_write_en,
   input  logic [hcg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hcg_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import hcg_pkg::*;

   logic [63:0]        key_ff [KEY_WORDS];
   logic [5:0]         key_len_ff;
   logic [3:0]         digits_ff;
   logic [KEY_W-1:0]   key_all;
   logic [BLOCK_W-1:0] key_pad;
   logic [BLOCK_W-1:0] key_blk;
   logic [5:0]         eff_len;
   midstate_type       ms;
   logic               advance;
   logic               accept;
   logic               digits_ok;

   logic               in_out_valid;
   logic [HASH_W-1:0]  in_out_state;
   logic               dg_v_ff;
   logic [HASH_W-1:0]  dg_ff;
   logic               out_out_valid;
   logic [HASH_W-1:0]  out_out_state;
   logic               mac_v_ff;
   logic [HASH_W-1:0]  mac_ff;
   logic [HASH_W-1:0]  mac_sel;
   logic               tr_v_ff;
   logic [DBC_W-1:0]   dbc_ff;
   logic               bcd_valid;
   logic [BCD_W-1:0]   bcd;
   logic [DBC_W-1:0]   bcd_bin;
   logic               hi_v_ff;
   logic [HI_W-1:0]    hi_ff;
   logic [HI_W-1:0]    hi_in;
   logic [35:0]        lo_ff;
   logic [35:0]        lo_in;
   logic [DBC_W-1:0]   bin_hi_ff;
   logic               mul_v_ff;
   logic [DBC_W-1:0]   prod_ff;
   logic [35:0]        lo_mul_ff;
   logic [DBC_W-1:0]   bin_mul_ff;
   logic               rsp_valid_ff;
   logic [29:0]        code_ff;
   logic [35:0]        bcd_out_ff;
   logic               status_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_WORDS; i++) begin
            key_ff[i] <= '0;
         end
         key_len_ff <= KEY_LEN_RESET;
         digits_ff  <= DIGITS_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_WORD_0:  key_ff[0]  <= csr_write_data;
            CSR_KEY_WORD_1:  key_ff[1]  <= csr_write_data;
            CSR_KEY_WORD_2:  key_ff[2]  <= csr_write_data;
            CSR_KEY_WORD_3:  key_ff[3]  <= csr_write_data;
            CSR_KEY_WORD_4:  key_ff[4]  <= csr_write_data;
            CSR_KEY_WORD_5:  key_ff[5]  <= csr_write_data;
            CSR_KEY_LENGTH:  key_len_ff <= csr_write_data[5:0];
            CSR_DIGIT_COUNT: digits_ff  <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   // key block, bytes past the saturated length read as zero
   always_comb begin
      key_all = {key_ff[0], key_ff[1], key_ff[2], key_ff[3], key_ff[4], key_ff[5]};
      key_pad = {key_all, (BLOCK_W - KEY_W)'(0)};
      eff_len = (key_len_ff > 6'(MAX_KEY_BYTES)) ? 6'(MAX_KEY_BYTES) : key_len_ff;
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         if (7'(i) < {1'b0, eff_len}) begin
            key_blk[BLOCK_W-1-8*i -: 8] = key_pad[BLOCK_W-1-8*i -: 8];
         end else begin
            key_blk[BLOCK_W-1-8*i -: 8] = 8'h00;
         end
      end
   end

   hcg_midstate u_midstate (
      .clock     (clock),
      .reset     (reset),
      .restart   (csr_write_en),
      .key_block (key_blk),
      .ms        (ms)
   );

   // global pipeline enable
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !ms.ready || !advance;
   assign accept    = req_valid && !req_stall;

   // inner hash, second block: counter and padding
   hcg_compress u_inner (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (accept),
      .in_state  (ms.ihash),
      .in_block  ({req_moving_factor, PAD_WORD, 352'd0, INNER_LEN_BITS}),
      .out_valid (in_out_valid),
      .out_state (in_out_state)
   );

   // inner digest
   always_ff @(posedge clock) begin
      if (reset) begin
         dg_v_ff <= 1'b0;
      end else if (advance) begin
         dg_v_ff <= in_out_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         dg_ff <= hash_add(ms.ihash, in_out_state);
      end
   end

   // outer hash, second block: inner digest and padding
   hcg_compress u_outer (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (dg_v_ff),
      .in_state  (ms.ohash),
      .in_block  ({dg_ff, PAD_WORD, 256'd0, OUTER_LEN_BITS}),
      .out_valid (out_out_valid),
      .out_state (out_out_state)
   );

   // final mac, then dynamic truncation
   assign mac_sel = mac_ff << {mac_ff[3:0], 3'b000};

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_v_ff <= 1'b0;
         tr_v_ff  <= 1'b0;
      end else if (advance) begin
         mac_v_ff <= out_out_valid;
         tr_v_ff  <= mac_v_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         mac_ff <= hash_add(ms.ohash, out_out_state);
         dbc_ff <= mac_sel[HASH_W-2 -: DBC_W];
      end
   end

   hcg_bin2bcd u_bin2bcd (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (tr_v_ff),
      .in_bin    (dbc_ff),
      .out_valid (bcd_valid),
      .out_bcd   (bcd),
      .out_bin   (bcd_bin)
   );

   // digits above the code length as a binary quotient, low digits kept
   always_comb begin
      unique case (digits_ff)
         4'd6: begin
            hi_in = HI_W'(bcd[39:36] * 1000 + bcd[35:32] * 100 + bcd[31:28] * 10
                          + bcd[27:24]);
            lo_in = {12'd0, bcd[23:0]};
         end
         4'd7: begin
            hi_in = HI_W'(bcd[39:36] * 100 + bcd[35:32] * 10 + bcd[31:28]);
            lo_in = {8'd0, bcd[27:0]};
         end
         4'd8: begin
            hi_in = HI_W'(bcd[39:36] * 10 + bcd[35:32]);
            lo_in = {4'd0, bcd[31:0]};
         end
         4'd9: begin
            hi_in = HI_W'(bcd[39:36]);
            lo_in = bcd[35:0];
         end
         default: begin
            hi_in = '0;
            lo_in = '0;
         end
      endcase
   end

   assign digits_ok = (digits_ff >= MIN_DIGITS) && (digits_ff <= MAX_DIGITS);

   // quotient stage, multiply stage, output register
   always_ff @(posedge clock) begin
      if (reset) begin
         hi_v_ff      <= 1'b0;
         mul_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         hi_v_ff      <= bcd_valid;
         mul_v_ff     <= hi_v_ff;
         rsp_valid_ff <= mul_v_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         hi_ff      <= hi_in;
         lo_ff      <= lo_in;
         bin_hi_ff  <= bcd_bin;
         prod_ff    <= DBC_W'(hi_ff * ten_pow(digits_ff));
         lo_mul_ff  <= lo_ff;
         bin_mul_ff <= bin_hi_ff;
         if (digits_ok) begin
            code_ff    <= 30'(bin_mul_ff - prod_ff);
            bcd_out_ff <= lo_mul_ff;
            status_ff  <= 1'b0;
         end else begin
            code_ff    <= '0;
            bcd_out_ff <= '0;
            status_ff  <= 1'b1;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code_value = code_ff;
   assign rsp_code_bcd   = bcd_out_ff;
   assign rsp_status     = status_ff;

`ifndef NO_ASSERTIONS
   // no transaction is taken while the key midstates are stale
   assert property (@(posedge clock) disable iff (reset) !ms.ready |-> req_stall)
      else $error("transaction accepted before key midstates were ready");

   // a register write starts a rehash and blocks the request side
   assert property (@(posedge clock) disable iff (reset) csr_write_en |=> req_stall)
      else $error("request side open right after a register write");

   // error results carry a zero code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> (rsp_code_value == 30'd0) && (rsp_code_bcd == 36'd0))
      else $error("nonzero code with digit count error");

   // reduced code stays below ten to the ninth
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_code_value < 30'd1000000000))
      else $error("code value out of range");
`endif

endmodule

FILE: hw/rtl/hcg_midstate.sv
// hcg_midstate: iterative sha-1 unit that hashes the ipad and opad key
// blocks after reset and after every register write; depends on hcg_pkg
module hcg_midstate (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         restart,
   input  logic [hcg_pkg::BLOCK_W-1:0] key_block,
   output hcg_pkg::midstate_type        ms
);
   import hcg_pkg::*;

   ms_state_type        state_ff, state_in;
   logic [6:0]          cnt_ff, cnt_in;
   logic [HASH_W-1:0]   s_ff, s_in;
   logic [BLOCK_W-1:0]  w_ff, w_in;
   logic [HASH_W-1:0]   ihash_ff, ihash_in;
   logic [HASH_W-1:0]   ohash_ff, ohash_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MS_LOAD_IN;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      s_ff     <= s_in;
      w_ff     <= w_in;
      ihash_ff <= ihash_in;
      ohash_ff <= ohash_in;
   end

   // next state and round datapath
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      s_in     = s_ff;
      w_in     = w_ff;
      ihash_in = ihash_ff;
      ohash_in = ohash_ff;
      unique case (state_ff)
         MS_LOAD_IN: begin
            s_in     = SHA1_INIT;
            w_in     = key_block ^ IPAD_BLOCK;
            cnt_in   = '0;
            state_in = MS_RUN_IN;
         end
         MS_RUN_IN: begin
            s_in   = sha1_round(s_ff, w_ff[BLOCK_W-1 -: 32], cnt_ff);
            w_in   = sched_next(w_ff);
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'(ROUNDS - 1)) begin
               state_in = MS_LOAD_OUT;
            end
         end
         MS_LOAD_OUT: begin
            ihash_in = hash_add(SHA1_INIT, s_ff);
            s_in     = SHA1_INIT;
            w_in     = key_block ^ OPAD_BLOCK;
            cnt_in   = '0;
            state_in = MS_RUN_OUT;
         end
         MS_RUN_OUT: begin
            s_in   = sha1_round(s_ff, w_ff[BLOCK_W-1 -: 32], cnt_ff);
            w_in   = sched_next(w_ff);
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'(ROUNDS - 1)) begin
               state_in = MS_STORE;
            end
         end
         MS_STORE: begin
            ohash_in = hash_add(SHA1_INIT, s_ff);
            state_in = MS_READY;
         end
         MS_READY: begin
            state_in = MS_READY;
         end
         default: begin
            state_in = MS_LOAD_IN;
         end
      endcase
      // any register write invalidates the midstates
      if (restart) begin
         state_in = MS_LOAD_IN;
      end
   end

   assign ms.ready = (state_ff == MS_READY);
   assign ms.ihash = ihash_ff;
   assign ms.ohash = ohash_ff;

endmodule

FILE: hw/rtl/hcg_compress.sv
// hcg_compress: one sha-1 compression unrolled into 80 round stages,
// one round per register stage; depends on hcg_pkg
module hcg_compress (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  logic [hcg_pkg::HASH_W-1:0]  in_state,
   input  logic [hcg_pkg::BLOCK_W-1:0] in_block,
   output logic                         out_valid,
   output logic [hcg_pkg::HASH_W-1:0]  out_state
);
   import hcg_pkg::*;

   logic [ROUNDS-1:0]  v_ff;
   logic [HASH_W-1:0]  s_ff [ROUNDS];
   logic [BLOCK_W-1:0] w_ff [ROUNDS-1];

   // valid bits travel with the rounds
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[ROUNDS-2:0], in_valid};
      end
   end

   // round stages, schedule window shifts alongside
   always_ff @(posedge clock) begin
      if (advance) begin
         s_ff[0] <= sha1_round(in_state, in_block[BLOCK_W-1 -: 32], 7'd0);
         w_ff[0] <= sched_next(in_block);
         for (int r = 1; r < ROUNDS; r++) begin
            s_ff[r] <= sha1_round(s_ff[r-1], w_ff[r-1][BLOCK_W-1 -: 32], 7'(r));
         end
         for (int r = 1; r < ROUNDS - 1; r++) begin
            w_ff[r] <= sched_next(w_ff[r-1]);
         end
      end
   end

   assign out_valid = v_ff[ROUNDS-1];
   assign out_state = s_ff[ROUNDS-1];

endmodule

FILE: hw/rtl/hcg_bin2bcd.sv
// hcg_bin2bcd: pipelined double dabble, four bits per stage, carries the
// binary value along; depends on hcg_pkg
module hcg_bin2bcd (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  logic [hcg_pkg::DBC_W-1:0] in_bin,
   output logic                       out_valid,
   output logic [hcg_pkg::BCD_W-1:0] out_bcd,
   output logic [hcg_pkg::DBC_W-1:0] out_bin
);
   import hcg_pkg::*;

   localparam int SH_W = BCD_STAGES * BCD_STEPS;

   logic [BCD_STAGES-1:0] v_ff;
   logic [BCD_W-1:0]      bcd_ff [BCD_STAGES];
   logic [SH_W-1:0]       sh_ff  [BCD_STAGES-1];
   logic [DBC_W-1:0]      bin_ff [BCD_STAGES];
   logic [BCD_W-1:0]      step_in [BCD_STAGES];
   logic [SH_W-1:0]       sh_src [BCD_STAGES];

   // per-stage conversion steps
   always_comb begin
      for (int s = 0; s < BCD_STAGES; s++) begin
         if (s == 0) begin
            sh_src[s]  = SH_W'(in_bin);
            step_in[s] = '0;
         end else begin
            sh_src[s]  = sh_ff[(s > 0) ? s - 1 : 0];
            step_in[s] = bcd_ff[(s > 0) ? s - 1 : 0];
         end
         for (int k = 0; k < BCD_STEPS; k++) begin
            step_in[s] = dabble_step(step_in[s], sh_src[s][SH_W-1-k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[BCD_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         bin_ff[0] <= in_bin;
         for (int s = 0; s < BCD_STAGES; s++) begin
            bcd_ff[s] <= step_in[s];
         end
         for (int s = 0; s < BCD_STAGES - 1; s++) begin
            sh_ff[s] <= sh_src[s] << BCD_STEPS;
         end
         for (int s = 1; s < BCD_STAGES; s++) begin
            bin_ff[s] <= bin_ff[s-1];
         end
      end
   end

   assign out_valid = v_ff[BCD_STAGES-1];
   assign out_bcd   = bcd_ff[BCD_STAGES-1];
   assign out_bin   = bin_ff[BCD_STAGES-1];

endmodule

FILE: bench/testbench.sv
// testbench for hotp_code_generator_top: hmac-sha1 hotp codes checked
// against a predictor built here; depends on hcg_pkg and the rtl under hw/rtl
`timescale 1ns / 100ps

module testbench;
   import hcg_pkg::*;

   typedef struct {
      logic [29:0] code;
      logic [35:0] bcd;
      logic        status;
   } hotp_code_type;

   typedef enum int {KEY_ZERO, KEY_RFC, KEY_ONES} key_pick_type;

   typedef struct {
      key_pick_type key;
      logic [5:0]   klen;
      logic [3:0]   digits;
      logic [63:0]  factor;
      bit           known;
      logic [29:0]  code;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_moving_factor = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [29:0] rsp_code_value;
   logic [35:0] rsp_code_bcd;
   logic        rsp_status;
   logic        csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   // predictor copy of the registers
   logic [63:0] key_words [KEY_WORDS];
   logic [5:0]  key_len_reg;
   logic [3:0]  digit_reg;

   hotp_code_type pending_codes [$];
   int  mismatch_count = 0;
   bit  calm = 1'b0;
   bit  hold_request = 1'b0;

   hotp_code_generator_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

   // one sha-1 compression
   function automatic logic [159:0] sha1_block(input logic [159:0] h, input logic [511:0] blk);
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) w[i] = blk[511-32*i -: 32];
      for (int i = 16; i < 80; i++) begin
         t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
         w[i] = {t[30:0], t[31]};
      end
      {a, b, c, d, e} = h;
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d); k = 32'h5A82_7999;
         end else if (i < 40) begin
            f = b ^ c ^ d; k = 32'h6ED9_EBA1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d); k = 32'h8F1B_BCDC;
         end else begin
            f = b ^ c ^ d; k = 32'hCA62_C1D6;
         end
         t = {a[26:0], a[31:27]} + f + e + k + w[i];
         e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
      end
      return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
   endfunction

   function automatic logic [35:0] to_bcd(input logic [29:0] v);
      logic [35:0] r;
      int unsigned x;
      r = '0;
      x = v;
      for (int i = 0; i < 9; i++) begin
         r[4*i +: 4] = x % 10;
         x = x / 10;
      end
      return r;
   endfunction

   // hmac-sha1, dynamic truncation and decimal reduction
   function automatic hotp_code_type predict_code(input logic [63:0] factor);
      hotp_code_type res;
      logic [511:0] ipad_blk, opad_blk, tail;
      logic [159:0] inner, mac, st;
      logic [7:0]  kb;
      logic [3:0]  off;
      logic [31:0] dbc;
      int unsigned eff, modulus;
      res = '{code: '0, bcd: '0, status: 1'b1};
      if (digit_reg < 4'd6 || digit_reg > 4'd9) return res;
      eff = (key_len_reg > 6'd48) ? 48 : key_len_reg;
      for (int i = 0; i < 64; i++) begin
         kb = (i < eff) ? key_words[i/8][63-8*(i%8) -: 8] : 8'h00;
         ipad_blk[511-8*i -: 8] = kb ^ 8'h36;
         opad_blk[511-8*i -: 8] = kb ^ 8'h5C;
      end
      tail = {factor, 8'h80, {(512-72-64){1'b0}}, 64'd576};
      st = sha1_block(SHA1_INIT, ipad_blk);
      inner = sha1_block(st, tail);
      tail = {inner, 8'h80, {(512-168-64){1'b0}}, 64'd672};
      st = sha1_block(SHA1_INIT, opad_blk);
      mac = sha1_block(st, tail);
      off = mac[3:0];
      dbc = mac[159-8*off -: 32];
      dbc[31] = 1'b0;
      case (digit_reg)
         4'd6: modulus = 1000000;
         4'd7: modulus = 10000000;
         4'd8: modulus = 100000000;
         default: modulus = 1000000000;
      endcase
      res.code = dbc % modulus;
      res.bcd = to_bcd(res.code);
      res.status = 1'b0;
      return res;
   endfunction

   task automatic csr_write(input csr_index_type idx, input logic [63:0] data);
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_codes.size() != 0) @(negedge clock);
   endtask

   // program every register while idle
   task automatic program_block(input logic [63:0] words [KEY_WORDS], input logic [5:0] klen,
                                input logic [3:0] digits);
      wait_drained();
      for (int i = 0; i < KEY_WORDS; i++) begin
         csr_write(csr_index_type'(CSR_KEY_WORD_0 + i), words[i]);
         key_words[i] = words[i];
      end
      csr_write(CSR_KEY_LENGTH, {58'd0, klen});
      csr_write(CSR_DIGIT_COUNT, {60'd0, digits});
      key_len_reg = klen;
      digit_reg = digits;
   endtask

   // offer one transaction and log its expectation once taken
   task automatic send_factor(input logic [63:0] factor, input bit known,
                              input hotp_code_type typed);
      while (!calm && $urandom_range(99) < 28) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_moving_factor = factor;
      do @(posedge clock); while (req_stall);
      pending_codes.push_back(known ? typed : predict_code(factor));
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      hotp_code_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_codes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result code %0d", rsp_code_value);
         end else begin
            want = pending_codes.pop_front();
            if (rsp_code_value !== want.code || rsp_code_bcd !== want.bcd ||
                rsp_status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp code %0d bcd %h status %b, got %0d %h %b",
                           want.code, want.bcd, want.status,
                           rsp_code_value, rsp_code_bcd, rsp_status);
            end
         end
      end
   end

   // result side stalls, with one long hold-off on request
   initial begin
      @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_stall = 1'b1;
            repeat (600) @(negedge clock);
            hold_request = 1'b0;
         end
         rsp_stall = !calm && ($urandom_range(99) < 28);
         @(negedge clock);
      end
   end

   initial begin
      stim_row_type  table_rows [$];
      stim_row_type  row;
      logic [63:0]   words [KEY_WORDS];
      logic [63:0]   factor;
      logic [5:0]    klen;
      logic [3:0]    digits;
      hotp_code_type typed;
      key_pick_type  cur_key;
      int            sent;

      // reset values
      for (int i = 0; i < KEY_WORDS; i++) key_words[i] = '0;
      key_len_reg = KEY_LEN_RESET;
      digit_reg = DIGITS_RESET;
      cur_key = KEY_ZERO;

      // directed stimulus: reset config first, then the published test vectors
      table_rows = '{
         '{KEY_ZERO, 6'd20, 4'd6, 64'd0, 0, 0},
         '{KEY_ZERO, 6'd20, 4'd6, '1, 0, 0},
         '{KEY_ZERO, 6'd20, 4'd6, 64'h8000_0000_0000_0001, 0, 0},
         '{KEY_RFC, 6'd20, 4'd6, 64'd0, 1, 30'd755224},
         '{KEY_RFC, 6'd20, 4'd6, 64'd1, 1, 30'd287082},
         '{KEY_RFC, 6'd20, 4'd6, 64'd2, 1, 30'd359152},
         '{KEY_RFC, 6'd20, 4'd6, 64'd3, 1, 30'd969429},
         '{KEY_RFC, 6'd20, 4'd6, 64'd4, 1, 30'd338314},
         '{KEY_RFC, 6'd20, 4'd6, 64'd5, 1, 30'd254676},
         '{KEY_RFC, 6'd20, 4'd6, 64'd6, 1, 30'd287922},
         '{KEY_RFC, 6'd20, 4'd6, 64'd7, 1, 30'd162583},
         '{KEY_RFC, 6'd20, 4'd6, 64'd8, 1, 30'd399871},
         '{KEY_RFC, 6'd20, 4'd6, 64'd9, 1, 30'd520489},
         '{KEY_RFC, 6'd20, 4'd9, 64'd9, 0, 0},
         // digit count out of range gives zero code and error status
         '{KEY_RFC, 6'd20, 4'd0, 64'd1, 1, 30'd0},
         '{KEY_RFC, 6'd20, 4'd5, '1, 1, 30'd0},
         '{KEY_RFC, 6'd20, 4'd10, 64'd3, 1, 30'd0},
         '{KEY_RFC, 6'd20, 4'd15, 64'd4, 1, 30'd0},
         // empty key, full key, and a length past the register space
         '{KEY_ONES, 6'd0, 4'd8, 64'd5, 0, 0},
         '{KEY_ONES, 6'd48, 4'd7, '1, 0, 0},
         '{KEY_ONES, 6'd63, 4'd9, 64'd0, 0, 0}
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (table_rows[r]) begin
         row = table_rows[r];
         if (row.key != cur_key || row.klen != key_len_reg || row.digits != digit_reg) begin
            for (int i = 0; i < KEY_WORDS; i++)
               words[i] = (row.key == KEY_ONES) ? '1 : '0;
            if (row.key == KEY_RFC) begin
               words[0] = 64'h3132_3334_3536_3738;
               words[1] = 64'h3930_3132_3334_3536;
               words[2] = 64'h3738_3930_0000_0000;
            end
            program_block(words, row.klen, row.digits);
            cur_key = row.key;
         end
         typed.code = row.code;
         typed.bcd = to_bcd(row.code);
         typed.status = (row.digits < 4'd6 || row.digits > 4'd9);
         send_factor(row.factor, row.known, typed);
      end

      // random part: a new random setting every couple of hundred transactions
      sent = 0;
      while (sent < 1900) begin
         for (int i = 0; i < KEY_WORDS; i++) words[i] = {$urandom, $urandom};
         case ($urandom_range(5))
            0: klen = 6'd0;
            1: klen = 6'd48;
            2: klen = 6'($urandom_range(63));
            default: klen = 6'($urandom_range(1, 48));
         endcase
         digits = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(6, 9));
         program_block(words, klen, digits);
         for (int j = 0; j < 200 && sent < 1900; j++) begin
            calm = (sent >= 400 && sent < 600);
            if (sent == 800) hold_request = 1'b1;
            if (sent == 1200) begin
               req_valid = 1'b0;
               wait_drained();
            end
            case ($urandom_range(3))
               0: factor = 64'($urandom_range(1000));
               1: factor = $urandom_range(1) ? '1 : 64'h8000_0000_0000_0000 | {$urandom, $urandom};
               default: factor = {$urandom, $urandom};
            endcase
            send_factor(factor, 1'b0, typed);
            sent++;
         end
      end
      calm = 1'b0;
      req_valid = 1'b0;

      wait_drained();
      repeat (200) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/hcg_pkg.sv
hw/rtl/hcg_midstate.sv
hw/rtl/hcg_compress.sv
hw/rtl/hcg_bin2bcd.sv
hw/rtl/hotp_code_generator_top.sv
bench/testbench.sv
